// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the status LED pattern sequencer.
// Needs a clock named clk and an active-low reset named rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on the rising edge and switched off during reset.
`define SLPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that also holds while reset is asserted.
`define SLPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/slps_pkg.sv -----
// Package for the status LED pattern sequencer: opcodes, mode codes, pattern constants
// and the pattern helper functions. Depends on nothing.
package slps_pkg;

  localparam int PHASE_W = 11;
  localparam int DUR_W   = 16;
  localparam int HALF_W  = 9;
  localparam int FREQ_W  = 8;
  localparam int DIV_W   = 5;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_SET_MODE = 2'd1;
  localparam logic [1:0] OP_IDENTIFY = 2'd2;

  localparam logic [1:0] MODE_UNCONF   = 2'd0;
  localparam logic [1:0] MODE_RUNNING  = 2'd1;
  localparam logic [1:0] MODE_IDENTIFY = 2'd2;

  localparam logic [PHASE_W-1:0] UNCONF_PERIOD = 11'd2000;
  localparam logic [PHASE_W-1:0] RUN_PERIOD    = 11'd1500;
  localparam logic [PHASE_W-1:0] UNCONF_ON_END = 11'd50;
  localparam logic [PHASE_W-1:0] RUN_PULSE1_END   = 11'd100;
  localparam logic [PHASE_W-1:0] RUN_PULSE2_START = 11'd200;
  localparam logic [PHASE_W-1:0] RUN_PULSE2_END   = 11'd300;
  localparam logic [PHASE_W-1:0] RUN_PULSE3_START = 11'd400;
  localparam logic [PHASE_W-1:0] RUN_PULSE3_END   = 11'd500;

  localparam logic [DUR_W-1:0]  DEFAULT_LENGTH = 16'd5000;
  localparam logic [DIV_W-1:0]  FREQ_MAX       = 5'd20;
  localparam logic [HALF_W-1:0] HALF_MIN       = 9'd25;
  localparam logic [HALF_W-1:0] HALF_RESET     = 9'd250;
  localparam logic [HALF_W-1:0] HALF_DIVIDEND  = 9'd500;

  // Period of the pattern shown in the given mode, in milliseconds.
  function automatic logic [PHASE_W-1:0] pattern_period(input logic [1:0] mode,
                                                        input logic [HALF_W-1:0] half);
    logic [PHASE_W-1:0] p;
    p = UNCONF_PERIOD;
    if (mode == MODE_IDENTIFY) begin
      p = {1'b0, half, 1'b0};
    end else if (mode == MODE_RUNNING) begin
      p = RUN_PERIOD;
    end
    return p;
  endfunction

  // LED level at the given phase of the given mode's pattern.
  function automatic logic pattern_level(input logic [1:0] mode,
                                         input logic [PHASE_W-1:0] phase,
                                         input logic [HALF_W-1:0] half);
    logic lvl;
    lvl = (phase < UNCONF_ON_END);
    if (mode == MODE_IDENTIFY) begin
      lvl = (phase < {2'b00, half});
    end else if (mode == MODE_RUNNING) begin
      lvl = (phase < RUN_PULSE1_END) ||
            ((phase >= RUN_PULSE2_START) && (phase < RUN_PULSE2_END)) ||
            ((phase >= RUN_PULSE3_START) && (phase < RUN_PULSE3_END));
    end
    return lvl;
  endfunction

endpackage

// ----- rtl/status_led_pattern_sequencer_top.sv -----
// Top level of the status LED pattern sequencer: mode state, tick handling and the
// bit-serial divider for the identify half period. Depends on slps_pkg and
// assert_macros.svh.

// The sequencer takes one beat per millisecond tick (opcode 0) and returns one result
// beat for it carrying the LED level and whether identify is showing; the set-mode
// (opcode 1) and start-identify (opcode 2) commands return nothing, and opcode 3 is
// accepted and ignored. A tick or a set-mode command is done in the cycle that accepts
// it. A start-identify command is accepted and then keeps the block busy while a
// restoring divider, one quotient bit per cycle, works out the half period as 500
// divided by the clamped frequency; in_stall is high while the divider runs. Results
// sit in an output register, so commands keep flowing while a result waits; only a
// tick is held off while the previous result has not been taken. The half period is
// never below 25 ms, and a zero duration selects 5000 ms. Reset is synchronous and
// restores the unconfigured pattern at phase 0.
module status_led_pattern_sequencer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_opcode,
  input  logic                         in_mode_value,
  input  logic [slps_pkg::FREQ_W-1:0]  in_frequency_hz,
  input  logic [slps_pkg::DUR_W-1:0]   in_duration_ms,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_led_on,
  output logic                         out_identify_active
);

  `include "assert_macros.svh"

  // Sequencer states: waiting for a beat, or running the divider.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  localparam logic [3:0] DIV_LAST_BIT = 4'd8;

  logic                          state_r, state_nxt;
  logic [1:0]                    mode_r, mode_nxt;
  logic                          resume_r, resume_nxt;
  logic [slps_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [slps_pkg::DUR_W-1:0]    elapsed_r, elapsed_nxt;
  logic [slps_pkg::DUR_W-1:0]    length_r, length_nxt;
  logic [slps_pkg::HALF_W-1:0]   half_r, half_nxt;

  // Divider working registers.
  logic [slps_pkg::DIV_W-1:0]    divisor_r, divisor_nxt;
  logic [slps_pkg::DIV_W-1:0]    rem_r, rem_nxt;
  logic [slps_pkg::HALF_W-1:0]   quot_r, quot_nxt;
  logic [3:0]                    bit_r, bit_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_led_r, out_led_nxt;
  logic                          out_ident_r, out_ident_nxt;

  logic                          in_accept;
  logic                          out_free;

  // Tick datapath.
  logic [slps_pkg::PHASE_W-1:0]  period;
  logic [slps_pkg::PHASE_W-1:0]  phase_inc;
  logic [slps_pkg::PHASE_W-1:0]  phase_adv;
  logic [slps_pkg::DUR_W-1:0]    elapsed_inc;
  logic                          in_identify;
  logic                          expire;
  logic [1:0]                    tick_mode;
  logic [slps_pkg::PHASE_W-1:0]  tick_phase;
  logic [slps_pkg::DUR_W-1:0]    tick_elapsed;

  // Divider step.
  logic [slps_pkg::DIV_W:0]      trial;
  logic                          trial_ge;
  logic [slps_pkg::HALF_W-1:0]   quot_step;
  logic [slps_pkg::DIV_W-1:0]    freq_clamped;

  assign out_free  = !out_valid_r || !out_stall;
  // A tick needs room in the output register; commands do not.
  assign in_stall  = (state_r == ST_DIV) || ((in_opcode == slps_pkg::OP_TICK) && !out_free);
  assign in_accept = in_valid && !in_stall;

  assign out_valid           = out_valid_r;
  assign out_led_on          = out_led_r;
  assign out_identify_active = out_ident_r;

  always_comb begin
    in_identify = (mode_r == slps_pkg::MODE_IDENTIFY);
    period      = slps_pkg::pattern_period(mode_r, half_r);
    phase_inc   = phase_r + 11'd1;
    phase_adv   = (phase_inc >= period) ? '0 : phase_inc;
    elapsed_inc = (elapsed_r != {slps_pkg::DUR_W{1'b1}}) ? elapsed_r + 16'd1 : elapsed_r;
    expire      = in_identify && (elapsed_inc >= length_r);
    tick_mode   = expire ? {1'b0, resume_r} : mode_r;
    tick_phase  = expire ? '0 : phase_adv;
    if (expire) begin
      tick_elapsed = '0;
    end else if (in_identify) begin
      tick_elapsed = elapsed_inc;
    end else begin
      tick_elapsed = elapsed_r;
    end
  end

  always_comb begin
    trial     = {rem_r, slps_pkg::HALF_DIVIDEND[bit_r]};
    trial_ge  = (trial >= {1'b0, divisor_r});
    quot_step = {quot_r[slps_pkg::HALF_W-2:0], trial_ge};
    if (in_frequency_hz == '0) begin
      freq_clamped = 5'd1;
    end else if (in_frequency_hz > {3'b000, slps_pkg::FREQ_MAX}) begin
      freq_clamped = slps_pkg::FREQ_MAX;
    end else begin
      freq_clamped = in_frequency_hz[slps_pkg::DIV_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    resume_nxt    = resume_r;
    phase_nxt     = phase_r;
    elapsed_nxt   = elapsed_r;
    length_nxt    = length_r;
    half_nxt      = half_r;
    divisor_nxt   = divisor_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_led_nxt   = out_led_r;
    out_ident_nxt = out_ident_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_opcode)
            slps_pkg::OP_TICK: begin
              mode_nxt      = tick_mode;
              phase_nxt     = tick_phase;
              elapsed_nxt   = tick_elapsed;
              out_valid_nxt = 1'b1;
              out_led_nxt   = slps_pkg::pattern_level(tick_mode, tick_phase, half_r);
              out_ident_nxt = (tick_mode == slps_pkg::MODE_IDENTIFY);
            end
            slps_pkg::OP_SET_MODE: begin
              resume_nxt = in_mode_value;
              if (!in_identify && (mode_r != {1'b0, in_mode_value})) begin
                mode_nxt  = {1'b0, in_mode_value};
                phase_nxt = '0;
              end
            end
            slps_pkg::OP_IDENTIFY: begin
              if (!in_identify) begin
                resume_nxt = mode_r[0];
              end
              mode_nxt    = slps_pkg::MODE_IDENTIFY;
              phase_nxt   = '0;
              elapsed_nxt = '0;
              length_nxt  = (in_duration_ms == '0) ? slps_pkg::DEFAULT_LENGTH : in_duration_ms;
              divisor_nxt = freq_clamped;
              rem_nxt     = '0;
              quot_nxt    = '0;
              bit_nxt     = DIV_LAST_BIT;
              state_nxt   = ST_DIV;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_nxt  = trial_ge ? trial[slps_pkg::DIV_W-1:0] - divisor_r
                            : trial[slps_pkg::DIV_W-1:0];
        quot_nxt = quot_step;
        if (bit_r == '0) begin
          half_nxt  = (quot_step < slps_pkg::HALF_MIN) ? slps_pkg::HALF_MIN : quot_step;
          state_nxt = ST_IDLE;
        end else begin
          bit_nxt = bit_r - 4'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= slps_pkg::MODE_UNCONF;
      resume_r    <= 1'b0;
      phase_r     <= '0;
      elapsed_r   <= '0;
      length_r    <= slps_pkg::DEFAULT_LENGTH;
      half_r      <= slps_pkg::HALF_RESET;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      resume_r    <= resume_nxt;
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      length_r    <= length_nxt;
      half_r      <= half_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    divisor_r   <= divisor_nxt;
    rem_r       <= rem_nxt;
    quot_r      <= quot_nxt;
    out_led_r   <= out_led_nxt;
    out_ident_r <= out_ident_nxt;
  end

  // The divider must not be disturbed by another beat.
  `SLPS_ASSERT(a_div_holds_input, (state_r == ST_DIV) |-> in_stall, "beat taken while dividing")
  // The half period always lies between its floor and 500 ms.
  `SLPS_ASSERT(a_half_range, (half_r >= slps_pkg::HALF_MIN) && (half_r <= slps_pkg::HALF_DIVIDEND), "half period out of range")
  // Outside the division the phase lies inside the current pattern period.
  `SLPS_ASSERT(a_phase_in_period, (state_r == ST_IDLE) |-> (phase_r < period), "phase beyond period")
  // A result that is held back keeps its value.
  `SLPS_ASSERT(a_result_held, (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_led_r) && $stable(out_ident_r)), "held result changed")

endmodule

// ----- tb/status_led_pattern_sequencer_top_test.sv -----
// Self-checking testbench for status_led_pattern_sequencer_top: directed, base-pattern
// and random beats are predicted in the testbench and compared with every LED result.
// Depends on slps_pkg and the sequencer RTL only.
module status_led_pattern_sequencer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The package names three opcodes; the fourth is accepted by the block and ignored.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int HALF_CLK     = 10;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_ITEMS = 700;
  // Cycles allowed after the last result before the verdict is drawn.
  localparam int DRAIN_CYCLES = 32;
  // Cycles without any beat on either channel before the run is abandoned. The
  // slowest legitimate gap is a receiver stall burst plus an identify division.
  localparam int STALL_LIMIT  = 2000;
  localparam int REPORT_LIMIT = 100;

  typedef struct packed {
    logic led_on;
    logic identify_active;
  } led_result_t;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_RANDOM,
    STALL_COMB,
    STALL_BURST
  } stall_style_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [1:0]                  in_opcode = slps_pkg::OP_TICK;
  logic                        in_mode_value = 1'b0;
  logic [slps_pkg::FREQ_W-1:0] in_frequency_hz = '0;
  logic [slps_pkg::DUR_W-1:0]  in_duration_ms = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_led_on;
  logic                        out_identify_active;

  // Shadow copy of the sequencer state, advanced once per accepted input beat.
  logic [1:0]                   mode_now;
  logic                         resume_base;
  logic [slps_pkg::PHASE_W-1:0] shadow_phase;
  logic [slps_pkg::DUR_W-1:0]   shadow_elapsed;
  logic [slps_pkg::DUR_W-1:0]   length_ms;
  logic [slps_pkg::HALF_W-1:0]  half_ms;

  // LED results predicted but not yet seen on the result channel, oldest first.
  led_result_t pending_led_results[$];

  int unsigned fail_count = 0;
  int unsigned reports_printed = 0;
  int unsigned results_checked = 0;
  int unsigned ticks_sent = 0;
  int unsigned commands_sent = 0;
  int unsigned counted_items = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_cycle = 0;
  stall_style_t stall_style = STALL_NONE;

  status_led_pattern_sequencer_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_mode_value       (in_mode_value),
    .in_frequency_hz     (in_frequency_hz),
    .in_duration_ms      (in_duration_ms),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_led_on          (out_led_on),
    .out_identify_active (out_identify_active)
  );

  always begin
    #HALF_CLK clk = 1'b1;
    #HALF_CLK clk = 1'b0;
  end

  // Works out the effect of one accepted beat on the shadow state. A tick also
  // records the LED level and identify flag that the block must return for it.
  task automatic predict_led_beat(input logic [1:0] op, input logic mode_v,
                                  input logic [slps_pkg::FREQ_W-1:0] freq,
                                  input logic [slps_pkg::DUR_W-1:0] dur);
    int unsigned period;
    int unsigned next_phase;
    int unsigned freq_clamped;
    int unsigned half_calc;
    led_result_t res;
    case (op)
      slps_pkg::OP_TICK: begin
        if (mode_now == slps_pkg::MODE_IDENTIFY) begin
          period = 32'({half_ms, 1'b0});
        end else if (mode_now == slps_pkg::MODE_RUNNING) begin
          period = 32'(slps_pkg::RUN_PERIOD);
        end else begin
          period = 32'(slps_pkg::UNCONF_PERIOD);
        end
        next_phase = (32'(shadow_phase) + 1) % period;
        shadow_phase = next_phase[slps_pkg::PHASE_W-1:0];
        if (mode_now == slps_pkg::MODE_IDENTIFY) begin
          // The elapsed count saturates rather than wrapping.
          if (shadow_elapsed != '1) begin
            shadow_elapsed = shadow_elapsed + 1'b1;
          end
          if (shadow_elapsed >= length_ms) begin
            mode_now = {1'b0, resume_base};
            shadow_phase = '0;
            shadow_elapsed = '0;
          end
        end
        res.identify_active = (mode_now == slps_pkg::MODE_IDENTIFY);
        if (mode_now == slps_pkg::MODE_IDENTIFY) begin
          res.led_on = (shadow_phase < {2'b00, half_ms});
        end else if (mode_now == slps_pkg::MODE_RUNNING) begin
          res.led_on = (shadow_phase < slps_pkg::RUN_PULSE1_END) ||
                       (shadow_phase >= slps_pkg::RUN_PULSE2_START &&
                        shadow_phase < slps_pkg::RUN_PULSE2_END) ||
                       (shadow_phase >= slps_pkg::RUN_PULSE3_START &&
                        shadow_phase < slps_pkg::RUN_PULSE3_END);
        end else begin
          res.led_on = (shadow_phase < slps_pkg::UNCONF_ON_END);
        end
        pending_led_results.push_back(res);
      end
      slps_pkg::OP_SET_MODE: begin
        // The remembered mode always follows; the shown mode only outside identify.
        resume_base = mode_v;
        if (mode_now != slps_pkg::MODE_IDENTIFY && mode_now != {1'b0, mode_v}) begin
          mode_now = {1'b0, mode_v};
          shadow_phase = '0;
        end
      end
      slps_pkg::OP_IDENTIFY: begin
        freq_clamped = 32'(freq);
        if (freq_clamped < 1) begin
          freq_clamped = 1;
        end
        if (freq_clamped > 32'(slps_pkg::FREQ_MAX)) begin
          freq_clamped = 32'(slps_pkg::FREQ_MAX);
        end
        half_calc = 32'(slps_pkg::HALF_DIVIDEND) / freq_clamped;
        if (half_calc < 32'(slps_pkg::HALF_MIN)) begin
          half_calc = 32'(slps_pkg::HALF_MIN);
        end
        // A restart during identify keeps the base mode remembered the first time.
        if (mode_now != slps_pkg::MODE_IDENTIFY) begin
          resume_base = mode_now[0];
        end
        mode_now = slps_pkg::MODE_IDENTIFY;
        shadow_phase = '0;
        shadow_elapsed = '0;
        length_ms = (dur == '0) ? slps_pkg::DEFAULT_LENGTH : dur;
        half_ms = half_calc[slps_pkg::HALF_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  // Sends one input beat. The sender works in bursts: when a burst runs out, valid
  // drops for a random gap before the next one starts. Within a burst valid stays
  // high from beat to beat, so it is never lowered and raised in the same step.
  task automatic send_beat(input logic [1:0] op, input logic mode_v,
                           input logic [slps_pkg::FREQ_W-1:0] freq,
                           input logic [slps_pkg::DUR_W-1:0] dur);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // Now and then a long burst gives a stretch with no idling on the input side.
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_mode_value   <= mode_v;
    in_frequency_hz <= freq;
    in_duration_ms  <= dur;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    predict_led_beat(op, mode_v, freq, dur);
    if (op == slps_pkg::OP_TICK) begin
      ticks_sent++;
    end else if (op != OP_UNUSED) begin
      commands_sent++;
    end
    if (op != OP_UNUSED) begin
      counted_items++;
    end
  endtask

  // A tick carries random content in the fields that it does not use.
  task automatic send_tick();
    send_beat(slps_pkg::OP_TICK, 1'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // Short directed sequence: reset pattern, the ignored opcode, set-mode with and
  // without a change, identify with clamped and default arguments, a duration of
  // one that expires on the first tick, set-mode while identify runs, and a
  // restart of identify that must keep the remembered base mode.
  task automatic test_directed_cases();
    send_tick();
    send_tick();
    send_beat(OP_UNUSED, 1'b1, '1, '1);
    send_tick();
    send_beat(slps_pkg::OP_SET_MODE, slps_pkg::MODE_UNCONF[0], '0, '0);
    send_tick();
    send_beat(slps_pkg::OP_SET_MODE, slps_pkg::MODE_RUNNING[0], '0, '0);
    send_tick();
    send_beat(slps_pkg::OP_SET_MODE, slps_pkg::MODE_RUNNING[0], '1, '1);
    send_tick();
    send_beat(slps_pkg::OP_IDENTIFY, 1'b0, 8'd255, 16'd1);
    send_tick();
    send_beat(slps_pkg::OP_IDENTIFY, 1'b1, 8'd0, 16'hFFFF);
    send_tick();
    send_beat(slps_pkg::OP_SET_MODE, slps_pkg::MODE_UNCONF[0], '0, '0);
    send_tick();
    send_beat(slps_pkg::OP_IDENTIFY, 1'b0, {3'b000, slps_pkg::FREQ_MAX}, 16'd2);
    send_tick();
    send_tick();
    send_beat(slps_pkg::OP_IDENTIFY, 1'b0, 8'd7, 16'd0);
    send_tick();
  endtask

  // Runs both base patterns from phase 0 through every lit window and a little
  // beyond, so that each edge of each pattern is seen.
  task automatic test_base_pattern_windows();
    // Leave identify through a one-millisecond session, then force a known mode.
    send_beat(slps_pkg::OP_IDENTIFY, 1'b0, {3'b000, slps_pkg::FREQ_MAX}, 16'd1);
    send_tick();
    send_beat(slps_pkg::OP_SET_MODE, slps_pkg::MODE_RUNNING[0], '0, '0);
    send_beat(slps_pkg::OP_SET_MODE, slps_pkg::MODE_UNCONF[0], '0, '0);
    repeat (int'(slps_pkg::UNCONF_ON_END) + 10) send_tick();
    send_beat(slps_pkg::OP_SET_MODE, slps_pkg::MODE_RUNNING[0], '0, '0);
    repeat (int'(slps_pkg::RUN_PULSE3_END) + 10) send_tick();
  endtask

  // Random sequences. Most are identify sessions with short half periods and short
  // lengths, so that blinks wrap and sessions expire often; set-mode and restarts
  // are mixed in. The rest are base-mode runs, pure noise over every field, and
  // sessions begun with arbitrary arguments and cut short by a restart.
  task automatic test_random_sequences();
    int unsigned start_count;
    int unsigned kind;
    int unsigned steps;
    int unsigned pick;
    logic [slps_pkg::FREQ_W-1:0] freq;
    logic [slps_pkg::DUR_W-1:0]  dur;
    start_count = counted_items;
    while (counted_items - start_count < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        freq = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(8, 255));
        dur  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1200))
                                           : 16'($urandom_range(1, 90));
        send_beat(slps_pkg::OP_IDENTIFY, 1'($urandom), freq, dur);
        steps = $urandom_range(0, (dur == '0) ? 200 : int'(dur) + 40);
        // A long session is cut to what is left of the item budget.
        if (steps > RANDOM_ITEMS - (counted_items - start_count)) begin
          steps = RANDOM_ITEMS - (counted_items - start_count);
        end
        repeat (steps) begin
          pick = $urandom_range(0, 99);
          if (pick < 6) begin
            send_beat(slps_pkg::OP_SET_MODE, 1'($urandom), 8'($urandom), 16'($urandom));
          end else if (pick < 8) begin
            send_beat(slps_pkg::OP_IDENTIFY, 1'($urandom), 8'($urandom_range(0, 255)),
                      16'($urandom_range(1, 60)));
          end else if (pick < 9) begin
            send_beat(OP_UNUSED, 1'($urandom), 8'($urandom), 16'($urandom));
          end else begin
            send_tick();
          end
        end
      end else if (kind < 80) begin
        send_beat(slps_pkg::OP_SET_MODE, 1'($urandom), 8'($urandom), 16'($urandom));
        repeat ($urandom_range(1, 80)) send_tick();
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 10)) begin
          send_beat(2'($urandom_range(0, 3)), 1'($urandom), 8'($urandom), 16'($urandom));
        end
      end else begin
        send_beat(slps_pkg::OP_IDENTIFY, 1'($urandom), 8'($urandom), 16'($urandom));
        repeat ($urandom_range(0, 6)) send_tick();
        send_beat(slps_pkg::OP_IDENTIFY, 1'($urandom), 8'($urandom_range(0, 255)),
                  16'($urandom_range(1, 30)));
        repeat ($urandom_range(0, 40)) send_tick();
      end
    end
  endtask

  // The receiver stalls on a style of its own, picked afresh whenever stall_cycle[7:0] is zero:
  // no stall, random stalls, a fixed comb of stalls, or long stall bursts.
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle[7:0] == 8'd0) begin
      stall_style <= stall_style_t'($urandom_range(0, 3));
    end
    case (stall_style)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
      STALL_COMB:   out_stall <= ((stall_cycle % 5) < 2);
      default:      out_stall <= (stall_cycle[5:0] < 6'd20);
    endcase
  end

  // Every result beat is compared with the oldest prediction, field by field.
  // Reports are capped so that a badly broken block does not flood the log.
  always @(posedge clk) begin
    led_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_led_results.size() == 0) begin
        fail_count++;
        if (reports_printed < REPORT_LIMIT) begin
          reports_printed++;
          $error("result beat arrived with no LED result predicted");
        end
      end else begin
        want = pending_led_results.pop_front();
        results_checked++;
        if (out_led_on !== want.led_on) begin
          fail_count++;
          if (reports_printed < REPORT_LIMIT) begin
            reports_printed++;
            $error("led_on: expected %0b, actual %0b", want.led_on, out_led_on);
          end
        end
        if (out_identify_active !== want.identify_active) begin
          fail_count++;
          if (reports_printed < REPORT_LIMIT) begin
            reports_printed++;
            $error("identify_active: expected %0b, actual %0b",
                   want.identify_active, out_identify_active);
          end
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no beat on either channel means a hang.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("status_led_pattern_sequencer_top_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // The shadow state starts from the block's reset values.
    mode_now       = slps_pkg::MODE_UNCONF;
    resume_base    = slps_pkg::MODE_UNCONF[0];
    shadow_phase   = '0;
    shadow_elapsed = '0;
    length_ms      = slps_pkg::DEFAULT_LENGTH;
    half_ms        = slps_pkg::HALF_RESET;

    // Reset is held for a fixed number of cycles, once, at the start.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_base_pattern_windows();
    test_random_sequences();

    // Everything is sent; drop valid and let the outstanding results drain.
    in_valid <= 1'b0;
    while (pending_led_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d ticks and %0d commands; %0d LED results were compared.",
             ticks_sent, commands_sent, results_checked);
    $display("Every lit window of both base patterns was crossed; identify sessions %s",
             "expired, restarted and clamped.");
    if (fail_count == 0) begin
      $display("status_led_pattern_sequencer_top_test: clean");
    end else begin
      $display("status_led_pattern_sequencer_top_test: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/slps_pkg.sv
rtl/status_led_pattern_sequencer_top.sv
tb/status_led_pattern_sequencer_top_test.sv
